/* rtl/dqd_pkg.sv */
package dqd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  entry_count;
    logic [VALUE_W-1:0]  front_value;
    logic [VALUE_W-1:0]  rear_value;
  } rsp_t;

endpackage

/* rtl/dqd_ram.sv */
module dqd_ram #(
  parameter int DEPTH      = dqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqd_pkg::DATA_WIDTH_DEF,
  parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_WIDTH-1:0] waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [ADDR_WIDTH-1:0] raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deque_with_item_delete_top.sv */
// Channel | Role   | Handshake           | Payload
// cmd     | input  | cmd_valid/cmd_ready | dqd_pkg::cmd_t (mode, value, index)
// rsp     | output | rsp_valid/rsp_ready | dqd_pkg::rsp_t (status, read_value, entry_count,
//         |        |                     |   front_value, rear_value)
//
// Push, clear, refused operations and a pop of the last entry go straight to the response;
// other pops and read index first load a word from the RAM. Delete scans, shifts entries past
// a hit down, reloads the ends if entries remain; one RAM read port scans and shifts an entry per cycle.
// One transaction is in flight at a time; the next is taken while the result waits in rsp.
// A stalled rsp holds the sequencer at its last step. Synchronous reset empties the deque;
// the entry RAM is not cleared.
module deque_with_item_delete_top #(
  parameter int DEPTH      = dqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqd_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  dqd_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dqd_pkg::rsp_t rsp
);

  import dqd_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int XW   = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_FRONT, S_LD_REAR, S_LD_READ, S_SCAN,
    S_SHIFT, S_REFRESH, S_LD_BOTH, S_DONE
  } state_t;

  state_t                state;
  logic [AW-1:0]         fp;
  logic [CW-1:0]         occ;
  logic [CW-1:0]         k;
  logic [DATA_WIDTH-1:0] word;
  logic [STATUS_W-1:0]   status;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [DATA_WIDTH-1:0] front_w;
  logic [DATA_WIDTH-1:0] rear_w;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  cmd_fire;
  logic [DATA_WIDTH-1:0] in_word;
  logic                  full;
  logic                  empty;
  logic                  multi;
  logic                  idx_ok;
  logic [CW-1:0]         occ_p1;
  logic [CW-1:0]         occ_m1;
  logic [CW-1:0]         occ_m2;
  logic [CW-1:0]         k_inc;
  logic [CW-1:0]         k_dec;
  logic                  last;
  logic                  rd_hit;
  logic [AW-1:0]         fp_dec;
  logic [AW-1:0]         fp_inc;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(ofs);
    if (sum >= SUMW'(DEPTH)) begin
      sum = sum - SUMW'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign in_word   = DATA_WIDTH'(cmd.value);
  assign full      = (occ == CW'(DEPTH));
  assign empty     = (occ == '0);
  assign multi     = (occ > CW'(1));
  assign idx_ok    = (XW'(cmd.index) < XW'(occ));
  assign occ_p1    = occ + CW'(1);
  assign occ_m1    = occ - CW'(1);
  assign occ_m2    = occ - CW'(2);
  assign k_inc     = k + CW'(1);
  assign k_dec     = k - CW'(1);
  assign last      = (k == occ_m1);
  assign rd_hit    = (rdata == word);
  assign fp_dec    = (fp == '0) ? AW'(DEPTH - 1) : fp - AW'(1);
  assign fp_inc    = slot_of(fp, CW'(1));

  always_comb begin
    we    = 1'b0;
    waddr = fp;
    wdata = in_word;
    re    = 1'b0;
    raddr = fp;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd.mode)
            MODE_PUSH_FRONT: begin
              we    = !full;
              waddr = fp_dec;
            end
            MODE_PUSH_REAR: begin
              we    = !full;
              waddr = slot_of(fp, occ);
            end
            MODE_POP_FRONT: begin
              re    = multi;
              raddr = fp_inc;
            end
            MODE_POP_REAR: begin
              re    = multi;
              raddr = slot_of(fp, occ_m2);
            end
            MODE_DELETE: begin
              re    = !empty;
              raddr = fp;
            end
            MODE_READ: begin
              re    = idx_ok;
              raddr = slot_of(fp, CW'(cmd.index));
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        re    = !last;
        raddr = slot_of(fp, k_inc);
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = slot_of(fp, k_dec);
        wdata = rdata;
        re    = !last;
        raddr = slot_of(fp, k_inc);
      end
      S_REFRESH: begin
        re    = !empty;
        raddr = fp;
      end
      S_LD_BOTH: begin
        re    = 1'b1;
        raddr = slot_of(fp, occ_m1);
      end
      default: ;
    endcase
  end

  dqd_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fp        <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            word   <= in_word;
            status <= ST_OK;
            rd_val <= '0;
            state  <= S_DONE;
            unique case (cmd.mode)
              MODE_PUSH_FRONT: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  fp      <= fp_dec;
                  occ     <= occ_p1;
                  front_w <= in_word;
                  if (empty) begin
                    rear_w <= in_word;
                  end
                end
              end
              MODE_PUSH_REAR: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  occ    <= occ_p1;
                  rear_w <= in_word;
                  if (empty) begin
                    front_w <= in_word;
                  end
                end
              end
              MODE_POP_FRONT: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  fp  <= fp_inc;
                  occ <= occ_m1;
                  if (multi) begin
                    state <= S_LD_FRONT;
                  end
                end
              end
              MODE_POP_REAR: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  occ <= occ_m1;
                  if (multi) begin
                    state <= S_LD_REAR;
                  end
                end
              end
              MODE_DELETE: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  k     <= '0;
                  state <= S_SCAN;
                end
              end
              MODE_READ: begin
                if (!idx_ok) begin
                  status <= ST_RANGE;
                end else begin
                  state <= S_LD_READ;
                end
              end
              MODE_CLEAR: begin
                occ <= '0;
                fp  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_LD_FRONT: begin
          front_w <= rdata;
          state   <= S_DONE;
        end
        S_LD_REAR: begin
          rear_w <= rdata;
          state  <= S_DONE;
        end
        S_LD_READ: begin
          rd_val <= rdata;
          state  <= S_DONE;
        end
        S_SCAN: begin
          if (rd_hit) begin
            if (last) begin
              occ   <= occ_m1;
              state <= S_REFRESH;
            end else begin
              k     <= k_inc;
              state <= S_SHIFT;
            end
          end else if (last) begin
            status <= ST_NOMATCH;
            state  <= S_DONE;
          end else begin
            k <= k_inc;
          end
        end
        S_SHIFT: begin
          if (last) begin
            occ   <= occ_m1;
            state <= S_REFRESH;
          end else begin
            k <= k_inc;
          end
        end
        S_REFRESH: begin
          state <= empty ? S_DONE : S_LD_BOTH;
        end
        S_LD_BOTH: begin
          front_w <= rdata;
          state   <= S_LD_REAR;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid           <= 1'b1;
            rsp.status          <= status;
            rsp.read_value      <= VALUE_W'(rd_val);
            rsp.entry_count     <= COUNT_W'(occ);
            rsp.front_value     <= empty ? '0 : VALUE_W'(front_w);
            rsp.rear_value      <= empty ? '0 : VALUE_W'(rear_w);
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/dqd_checker.sv */
module dqd_checker #(
  parameter int DEPTH = dqd_pkg::DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input dqd_pkg::rsp_t rsp
);

  import dqd_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.entry_count == '0 |-> rsp.front_value == '0 && rsp.rear_value == '0)
    else $error("empty deque shows nonzero front or rear");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == COUNT_W'(DEPTH))
    else $error("full refusal with deque not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.entry_count == '0)
    else $error("empty status with entries present");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_RANGE |-> rsp.read_value == '0)
    else $error("out of range read returned data");

endmodule

bind deque_with_item_delete_top dqd_checker #(.DEPTH(DEPTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

/* test/dqd_checker.sv */
module dqd_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  dqd_pkg::cmd_t cmd,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  dqd_pkg::rsp_t rsp,
  output int            mismatch_count,
  output int            awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dqd_pkg::*;

  logic [VALUE_W-1:0] entries_q[$];
  rsp_t               expected_rsp_q[$];

  function automatic rsp_t apply_deque_op(cmd_t c);
    rsp_t r;
    int   hit;
    r = '0;
    r.status = ST_OK;
    case (c.mode)
      MODE_PUSH_FRONT: begin
        if (entries_q.size() >= DEPTH_DEF) r.status = ST_FULL;
        else entries_q.push_front(c.value);
      end
      MODE_PUSH_REAR: begin
        if (entries_q.size() >= DEPTH_DEF) r.status = ST_FULL;
        else entries_q.push_back(c.value);
      end
      MODE_POP_FRONT: begin
        if (entries_q.size() == 0) r.status = ST_EMPTY;
        else void'(entries_q.pop_front());
      end
      MODE_POP_REAR: begin
        if (entries_q.size() == 0) r.status = ST_EMPTY;
        else void'(entries_q.pop_back());
      end
      MODE_DELETE: begin
        if (entries_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int k = 0; k < entries_q.size(); k++) begin
            if (hit < 0 && entries_q[k] == c.value) hit = k;
          end
          if (hit < 0) r.status = ST_NOMATCH;
          else entries_q.delete(hit);
        end
      end
      MODE_READ: begin
        if (int'(c.index) >= entries_q.size()) r.status = ST_RANGE;
        else r.read_value = entries_q[c.index];
      end
      MODE_CLEAR: begin
        entries_q.delete();
      end
      default: begin
      end
    endcase
    r.entry_count = COUNT_W'(entries_q.size());
    if (entries_q.size() != 0) begin
      r.front_value = entries_q[0];
      r.rear_value  = entries_q[$];
    end
    return r;
  endfunction

  task automatic compare_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      entries_q.delete();
      expected_rsp_q.delete();
      awaited_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: response with none outstanding, expected nothing, got %h", $time, rsp);
        end else begin
          want = expected_rsp_q.pop_front();
          compare_field("status", VALUE_W'(want.status), VALUE_W'(rsp.status));
          compare_field("read_value", want.read_value, rsp.read_value);
          compare_field("entry_count", VALUE_W'(want.entry_count), VALUE_W'(rsp.entry_count));
          compare_field("front_value", want.front_value, rsp.front_value);
          compare_field("rear_value", want.rear_value, rsp.rear_value);
        end
      end
      if (cmd_valid && cmd_ready) expected_rsp_q.push_back(apply_deque_op(cmd));
      awaited_count = expected_rsp_q.size();
    end
  end

endmodule

/* test/deque_with_item_delete_top_test.sv */
module deque_with_item_delete_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dqd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int ITEM_TARGET  = 1350;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 6;

  typedef enum {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_READ_SWEEP, SEQ_DELETE} seq_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   mismatch_count;
  int   awaited_count;

  int   stall_pct = 20;
  bit   gaps_on = 1'b1;
  bit   hold_req = 1'b0;
  int   burst_left = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  logic [VALUE_W-1:0] word_pool[POOL_SIZE];

  deque_with_item_delete_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  dqd_scoreboard u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[deque_with_item_delete_top] ERROR");
      $finish;
    end
  end

  initial begin
    int  run_left;
    bit  level;
    run_left = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        run_left = 0;
      end
      if (run_left == 0) begin
        level = ($urandom_range(99) >= stall_pct);
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      rsp_ready <= level;
    end
  end

  task automatic issue(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                       logic [IDX_W-1:0] index);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        cmd_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= '{mode: mode, value: value, index: index};
    do @(posedge clk); while (!cmd_ready);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    wait (awaited_count == 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    logic [VALUE_W-1:0] w;
    case ($urandom_range(3))
      0, 1: w = word_pool[$urandom_range(POOL_SIZE - 1)];
      2: w = $urandom;
      default: begin
        case ($urandom_range(2))
          0: w = '0;
          1: w = '1;
          default: w = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(1)) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom_range(3));
  endfunction

  task automatic random_op(seq_kind_e kind, int step);
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  index;
    int                r;
    index = pick_index();
    r = $urandom_range(99);
    case (kind)
      SEQ_FILL: mode = r < 50 ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      SEQ_DRAIN: mode = r < 12 ? MODE_DELETE : (r < 56 ? MODE_POP_FRONT : MODE_POP_REAR);
      SEQ_READ_SWEEP: begin
        mode = MODE_READ;
        index = IDX_W'(step);
      end
      SEQ_DELETE: mode = r < 60 ? MODE_DELETE : (r < 80 ? MODE_PUSH_REAR : MODE_PUSH_FRONT);
      default: begin
        if (r < 18) mode = MODE_PUSH_FRONT;
        else if (r < 36) mode = MODE_PUSH_REAR;
        else if (r < 48) mode = MODE_POP_FRONT;
        else if (r < 60) mode = MODE_POP_REAR;
        else if (r < 78) mode = MODE_DELETE;
        else if (r < 95) mode = MODE_READ;
        else if (r < 98) mode = MODE_CLEAR;
        else mode = MODE_UNUSED;
      end
    endcase
    issue(mode, pick_word(), index);
  endtask

  initial begin
    int        len;
    seq_kind_e kind;
    bit        held;
    bit        paused;
    int        seq_count;
    held = 1'b0;
    paused = 1'b0;
    seq_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(MODE_POP_FRONT, '0, '0);
    issue(MODE_POP_REAR, '1, '1);
    issue(MODE_DELETE, '0, '0);
    issue(MODE_READ, '0, '0);
    issue(MODE_READ, '0, 4'd15);
    issue(MODE_PUSH_FRONT, '0, '0);
    issue(MODE_PUSH_REAR, '1, '1);
    issue(MODE_PUSH_FRONT, 32'hA5A5_A5A5, '0);
    issue(MODE_PUSH_REAR, 32'h5A5A_5A5A, '0);
    issue(MODE_READ, '0, '0);
    issue(MODE_READ, '0, 4'd3);
    issue(MODE_READ, '0, 4'd4);
    issue(MODE_READ, '1, 4'd15);
    issue(MODE_DELETE, 32'h1234_5678, '0);
    issue(MODE_DELETE, '1, '0);
    issue(MODE_UNUSED, 32'hDEAD_BEEF, 4'd9);
    issue(MODE_POP_FRONT, '0, '0);
    issue(MODE_POP_REAR, '0, '0);
    issue(MODE_CLEAR, '1, '1);
    issue(MODE_POP_FRONT, '0, '0);
    issue(MODE_READ, '0, '0);

    while (items_sent < ITEM_TARGET) begin
      seq_count++;
      kind = seq_count == 1 ? SEQ_FILL : seq_kind_e'($urandom_range(4));
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 40;
        default: stall_pct = 85;
      endcase
      gaps_on = $urandom_range(2) != 0;
      if (stall_pct == 0 && $urandom_range(1)) gaps_on = 1'b0;
      foreach (word_pool[i]) word_pool[i] = $urandom;
      len = seq_count == 1 ? 22 : $urandom_range(8, 40);
      for (int step = 0; step < len; step++) begin
        random_op(kind, step);
        if (!held && items_sent > 400) begin
          held = 1'b1;
          hold_req = 1'b1;
        end
      end
      if ((!paused && items_sent > 800) || $urandom_range(5) == 0) begin
        paused = 1'b1;
        pause_until_drained();
      end
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    wait (awaited_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("[deque_with_item_delete_top] OK");
    end else begin
      $display("[deque_with_item_delete_top] ERROR");
    end
    $finish;
  end

endmodule
